[rtl/fair_reader_writer_lock_arbiter_top_assert.svh]
// Assertion macros for the fair reader-writer lock arbiter.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef FAIR_READER_WRITER_LOCK_ARBITER_TOP_ASSERT_SVH
`define FAIR_READER_WRITER_LOCK_ARBITER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FRWL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FRWL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/frwl_pkg.sv]
// Shared types, codes and defaults for the fair reader-writer lock arbiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package frwl_pkg;

    // Default configuration
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int MAX_READERS_DEF = 255;

    // Port field widths
    localparam int REQ_W    = 2;
    localparam int ID_OUT_W = 8;
    localparam int STATUS_W = 3;
    localparam int ID_EXT_W = 16;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_READ_LOCK    = 2'd0,
        REQ_WRITE_LOCK   = 2'd1,
        REQ_READ_UNLOCK  = 2'd2,
        REQ_WRITE_UNLOCK = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_READ_OK    = 3'd0,
        ST_WRITE_OK   = 3'd1,
        ST_QUEUED     = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_FULL       = 3'd4,
        ST_BAD_UNLOCK = 3'd5,
        ST_OVERFLOW   = 3'd6
    } status_t;

    // Per-cell control: shift toward the head, or load a new waiter
    typedef struct packed {
        logic shift;
        logic load;
    } frwl_cell_ctl_t;

endpackage

[rtl/fair_reader_writer_lock_arbiter_top.sv]
// Top level of the fair reader-writer lock arbiter: request decode,
// holder counts, wakeup sequencer and result register.
// Depends on frwl_pkg, frwl_queue and the assertion macro header.
//
//  Channel  | Direction | tdata (low bit up) | tuser (low bit up) | tlast
//  ---------+-----------+--------------------+--------------------+-------------
//  s_ (req) | in        | requester_id[7:0]  | req_type[1:0]      | -
//  m_ (res) | out       | target_id[7:0]     | status[2:0]        | final result
//
// A request yields one result; an unlock that wakes waiters adds one
// result per granted waiter (one writer or up to MAX_READERS readers),
// paced by the single result register.
// A new request is taken once the previous one has put out its last result
// and the result register is empty or being drained the same cycle.
// Reset (aresetn low, synchronous) empties the queue and drops all holders.
// Stalls on m_tready hold the result and pause the wakeup sequence.
`timescale 1ns / 1ps

`include "fair_reader_writer_lock_arbiter_top_assert.svh"

module fair_reader_writer_lock_arbiter_top
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int MAX_READERS = MAX_READERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ID_OUT_W-1:0] s_tdata,   // [7:0] requester_id
    input  logic [REQ_W-1:0]    s_tuser,   // [1:0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ID_OUT_W-1:0] m_tdata,   // [7:0] target_id
    output logic [STATUS_W-1:0] m_tuser,   // [2:0] status
    output logic                m_tlast
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W  = $clog2(MAX_READERS + 1);

    typedef enum logic {
        S_IDLE,
        S_WAKE
    } state_t;

    state_t              state_reg, state_next;
    logic [RC_W-1:0]     rc_reg, rc_next;
    logic                writer_reg, writer_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [ID_OUT_W-1:0] m_tdata_reg, m_tdata_next;
    status_t             m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                out_free;
    logic                take;
    logic [ID_EXT_W-1:0] in_ext;
    logic [ID_BITS-1:0]  in_id;
    logic [ID_EXT_W-1:0] head_ext;
    logic                enq;
    logic                enq_is_read;
    logic                deq;
    logic [ID_BITS-1:0]  head_id;
    logic                head_is_read;
    logic                second_is_read;
    logic [RC_W-1:0]     rc_inc;
    logic                q_empty;
    logic                q_full;

    // Handshake and field decode
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign take     = s_tvalid && s_tready;
    assign in_ext   = ID_EXT_W'(s_tdata);
    assign in_id    = in_ext[ID_BITS-1:0];
    assign head_ext = ID_EXT_W'(head_id);
    assign rc_inc   = rc_reg + RC_W'(1);
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Waiter queue
    frwl_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_queue (
        .aclk          (aclk),
        .enq           (enq),
        .deq           (deq),
        .wr_idx        (count_reg[IDX_W-1:0]),
        .wr_id         (in_id),
        .wr_is_read    (enq_is_read),
        .head_id       (head_id),
        .head_is_read  (head_is_read),
        .second_is_read(second_is_read)
    );

    // Decode requests and sequence wakeup grants
    always_comb begin
        state_next    = state_reg;
        rc_next       = rc_reg;
        writer_next   = writer_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        enq           = 1'b0;
        enq_is_read   = 1'b0;
        deq           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ID_OUT_W'(in_id);
                    m_tlast_next  = 1'b1;
                    case (req_t'(s_tuser))
                        REQ_READ_LOCK: begin
                            if (q_empty && !writer_reg) begin
                                if (rc_reg == RC_W'(MAX_READERS)) begin
                                    m_tuser_next = ST_OVERFLOW;
                                end else begin
                                    rc_next      = rc_inc;
                                    m_tuser_next = ST_READ_OK;
                                end
                            end else if (q_full) begin
                                m_tuser_next = ST_FULL;
                            end else begin
                                enq          = 1'b1;
                                enq_is_read  = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                m_tuser_next = ST_QUEUED;
                            end
                        end
                        REQ_WRITE_LOCK: begin
                            if (q_empty && !writer_reg && rc_reg == '0) begin
                                writer_next  = 1'b1;
                                m_tuser_next = ST_WRITE_OK;
                            end else if (q_full) begin
                                m_tuser_next = ST_FULL;
                            end else begin
                                enq          = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                m_tuser_next = ST_QUEUED;
                            end
                        end
                        REQ_READ_UNLOCK: begin
                            if (rc_reg == '0) begin
                                m_tuser_next = ST_BAD_UNLOCK;
                            end else begin
                                rc_next      = rc_reg - RC_W'(1);
                                m_tuser_next = ST_RELEASED;
                                if (rc_reg == RC_W'(1) && !q_empty) begin
                                    m_tlast_next = 1'b0;
                                    state_next   = S_WAKE;
                                end
                            end
                        end
                        default: begin
                            if (!writer_reg) begin
                                m_tuser_next = ST_BAD_UNLOCK;
                            end else begin
                                writer_next  = 1'b0;
                                m_tuser_next = ST_RELEASED;
                                if (!q_empty) begin
                                    m_tlast_next = 1'b0;
                                    state_next   = S_WAKE;
                                end
                            end
                        end
                    endcase
                end
            end
            S_WAKE: begin
                // Grant the head: one writer, or readers one per cycle while the result register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = head_ext[ID_OUT_W-1:0];
                    deq           = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    if (!head_is_read) begin
                        writer_next  = 1'b1;
                        m_tuser_next = ST_WRITE_OK;
                        m_tlast_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        rc_next      = rc_inc;
                        m_tuser_next = ST_READ_OK;
                        if (count_reg >= CNT_W'(2) && second_is_read &&
                            rc_inc != RC_W'(MAX_READERS)) begin
                            m_tlast_next = 1'b0;
                        end else begin
                            m_tlast_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rc_reg       <= '0;
            writer_reg   <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rc_reg       <= rc_next;
            writer_reg   <= writer_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks on holder state and wakeup sequencing
    `FRWL_ASSERT_SAME(a_excl_hold, writer_reg, rc_reg == '0, "writer and readers hold together")
    `FRWL_ASSERT_SAME(a_wake_nonempty, state_reg == S_WAKE, !q_empty, "wakeup with empty queue")
    `FRWL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `FRWL_ASSERT_SAME(a_more_pending, m_tvalid_reg && !m_tlast_reg, state_reg == S_WAKE, "open result run without wakeup")
    `FRWL_ASSERT_NEXT(a_rel_clears, take && writer_reg && req_t'(s_tuser) == REQ_WRITE_UNLOCK && q_empty, !writer_reg, "write unlock kept writer")

endmodule

[rtl/frwl_cell.sv]
// One waiter slot of the shift queue: holds an id and its kind.
// Depends on frwl_pkg for the cell control struct.
`timescale 1ns / 1ps

module frwl_cell
    import frwl_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic               aclk,
    input  frwl_cell_ctl_t     ctl,
    input  logic [ID_BITS-1:0] nbr_id,
    input  logic               nbr_is_read,
    input  logic [ID_BITS-1:0] wr_id,
    input  logic               wr_is_read,
    output logic [ID_BITS-1:0] id_q,
    output logic               is_read_q
);

    logic [ID_BITS-1:0] id_reg;
    logic               is_read_reg;

    // Take the neighbor's entry on a shift, else load a new waiter
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            id_reg      <= nbr_id;
            is_read_reg <= nbr_is_read;
        end else if (ctl.load) begin
            id_reg      <= wr_id;
            is_read_reg <= wr_is_read;
        end
    end

    assign id_q      = id_reg;
    assign is_read_q = is_read_reg;

endmodule

[rtl/frwl_queue.sv]
// Waiter FIFO built as a chain of frwl_cell slots, head in cell 0.
// Depends on frwl_pkg and frwl_cell. Fill level is kept by the caller.
`timescale 1ns / 1ps

module frwl_queue
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
    input  logic               aclk,
    input  logic               enq,
    input  logic               deq,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [ID_BITS-1:0] wr_id,
    input  logic               wr_is_read,
    output logic [ID_BITS-1:0] head_id,
    output logic               head_is_read,
    output logic               second_is_read
);

    logic [ID_BITS-1:0] cell_id      [QUEUE_DEPTH];
    logic               cell_is_read [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        frwl_cell_ctl_t     ctl;
        logic [ID_BITS-1:0] nbr_id;
        logic               nbr_is_read;

        // Advance every slot on a dequeue; load only the first free slot
        assign ctl.shift = deq;
        assign ctl.load  = enq && (wr_idx == IDX_W'(i));

        // The tail cell pulls in an empty entry
        if (i == QUEUE_DEPTH - 1) begin : g_end
            assign nbr_id      = '0;
            assign nbr_is_read = 1'b0;
        end else begin : g_mid
            assign nbr_id      = cell_id[i+1];
            assign nbr_is_read = cell_is_read[i+1];
        end

        frwl_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .nbr_id     (nbr_id),
            .nbr_is_read(nbr_is_read),
            .wr_id      (wr_id),
            .wr_is_read (wr_is_read),
            .id_q       (cell_id[i]),
            .is_read_q  (cell_is_read[i])
        );
    end

    assign head_id        = cell_id[0];
    assign head_is_read   = cell_is_read[0];
    assign second_is_read = cell_is_read[1];

endmodule
